>>> rtl/depthwise_mac_requantize_macros.svh
// Assertion helpers for the depthwise MAC requantize block.
// Both sample on the rising edge of clk and are off while rst_n is low.
`ifndef DEPTHWISE_MAC_REQUANTIZE_MACROS_SVH
`define DEPTHWISE_MAC_REQUANTIZE_MACROS_SVH

// Same-cycle implication.
`define DMR_ASSERT_IMP(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("dmr check failed");

// Next-cycle implication.
`define DMR_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("dmr check failed");

`endif

>>> rtl/dmr_pkg.sv
package dmr_pkg;

    localparam int JOB_DEPTH  = 4;
    localparam int JOB_PTR_W  = $clog2(JOB_DEPTH);
    localparam int OUT_DEPTH  = 4;
    localparam int OUT_PTR_W  = $clog2(OUT_DEPTH);

    localparam int CFG_ADDR_W = 2;
    localparam int CFG_DATA_W = 8;

    localparam int ACC_W       = 32;
    localparam int PROD_W      = 2 * ACC_W;
    localparam int ROUND_SHIFT = 24;
    localparam int QUOT_W      = PROD_W - ROUND_SHIFT;
    localparam int CLAMP_W     = QUOT_W + 2;

    localparam logic signed [CLAMP_W-1:0] OUT_OFFSET = CLAMP_W'(128);

    typedef enum logic [CFG_ADDR_W-1:0] {
        REG_MIN_VALUE = 2'd0,
        REG_MAX_VALUE = 2'd1
    } cfg_reg_t;

    typedef struct packed {
        logic signed [ACC_W-1:0] sum;
        logic        [ACC_W-1:0] scale;
    } job_t;

    typedef struct packed {
        logic signed [CFG_DATA_W-1:0] min_value;
        logic signed [CFG_DATA_W-1:0] max_value;
    } clamp_cfg_t;

endpackage

>>> rtl/dmr_front.sv
module dmr_front (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                accept,
    input  logic signed [15:0]  sample,
    input  logic signed [15:0]  weight,
    input  logic signed [31:0]  bias,
    input  logic        [31:0]  scale,
    input  logic                first_tap,
    input  logic                last_tap,
    output logic                job_push,
    output dmr_pkg::job_t       job
);
    import dmr_pkg::*;

    logic signed [ACC_W-1:0] acc_reg;
    logic signed [ACC_W-1:0] acc_next;
    logic signed [ACC_W-1:0] product;
    logic signed [ACC_W-1:0] base;

    assign product  = ACC_W'(sample) * ACC_W'(weight);
    assign base     = first_tap ? bias : acc_reg;
    assign acc_next = base + product;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            acc_reg <= '0;
        end
        else if (accept)
        begin
            acc_reg <= acc_next;
        end
    end

    // hand a closed window to the job queue
    assign job_push  = accept && last_tap;
    assign job.sum   = acc_next;
    assign job.scale = scale;

endmodule

>>> rtl/dmr_job_queue.sv
module dmr_job_queue (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          push,
    input  dmr_pkg::job_t wdata,
    output logic          full,
    input  logic          pop,
    output logic          valid,
    output dmr_pkg::job_t rdata
);
    import dmr_pkg::*;

    job_t                 mem_reg [JOB_DEPTH];
    logic [JOB_PTR_W-1:0] wr_ptr_reg;
    logic [JOB_PTR_W-1:0] rd_ptr_reg;
    logic [JOB_PTR_W:0]   count_reg;
    logic                 do_wr;
    logic                 do_rd;

    assign full  = (count_reg == (JOB_PTR_W+1)'(JOB_DEPTH));
    assign valid = (count_reg != '0);
    assign do_wr = push && !full;
    assign do_rd = pop && valid;
    assign rdata = mem_reg[rd_ptr_reg];

    always_ff @(posedge clk)
    begin
        if (do_wr)
        begin
            mem_reg[wr_ptr_reg] <= wdata;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (do_wr)
            begin
                wr_ptr_reg <= wr_ptr_reg + 1'b1;
            end
            if (do_rd)
            begin
                rd_ptr_reg <= rd_ptr_reg + 1'b1;
            end
            if (do_wr && !do_rd)
            begin
                count_reg <= count_reg + 1'b1;
            end
            else if (do_rd && !do_wr)
            begin
                count_reg <= count_reg - 1'b1;
            end
        end
    end

endmodule

>>> rtl/dmr_back.sv
module dmr_back (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                job_valid,
    input  dmr_pkg::job_t       job,
    output logic                job_pop,
    input  dmr_pkg::clamp_cfg_t cfg,
    output logic                empty,
    input  logic                pop,
    output logic [7:0]          out_byte
);
    import dmr_pkg::*;

    logic                        a_valid_reg;
    logic                        a_neg_reg;
    logic [PROD_W-1:0]           a_prod_reg;
    logic                        b_valid_reg;
    logic                        b_neg_reg;
    logic [QUOT_W-1:0]           b_quot_reg;

    logic [ACC_W-1:0]            mag;
    logic [PROD_W-1:0]           rounded;
    logic signed [CLAMP_W-1:0]   quot_ext;
    logic signed [CLAMP_W-1:0]   level;
    logic signed [CLAMP_W-1:0]   hi_level;
    logic signed [CLAMP_W-1:0]   lo_level;
    logic signed [CLAMP_W-1:0]   clamped;

    logic [7:0]                  out_mem_reg [OUT_DEPTH];
    logic [OUT_PTR_W-1:0]        out_wr_ptr_reg;
    logic [OUT_PTR_W-1:0]        out_rd_ptr_reg;
    logic [OUT_PTR_W:0]          out_count_reg;
    logic [OUT_PTR_W+1:0]        in_flight;
    logic                        out_wr;
    logic                        out_rd;

    // reserve an output slot for every job in the pipe
    assign in_flight = (OUT_PTR_W+2)'(out_count_reg) + (OUT_PTR_W+2)'(a_valid_reg)
                     + (OUT_PTR_W+2)'(b_valid_reg);
    assign job_pop   = job_valid && (in_flight < (OUT_PTR_W+2)'(OUT_DEPTH));

    assign mag     = job.sum[ACC_W-1] ? ACC_W'(-job.sum) : ACC_W'(job.sum);
    assign rounded = a_prod_reg + (PROD_W'(1) << (ROUND_SHIFT - 1));

    always_ff @(posedge clk)
    begin
        if (job_pop)
        begin
            a_neg_reg  <= job.sum[ACC_W-1];
            a_prod_reg <= PROD_W'(mag) * PROD_W'(job.scale);
        end
        if (a_valid_reg)
        begin
            b_neg_reg  <= a_neg_reg;
            b_quot_reg <= rounded[PROD_W-1:ROUND_SHIFT];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            a_valid_reg <= 1'b0;
            b_valid_reg <= 1'b0;
        end
        else
        begin
            a_valid_reg <= job_pop;
            b_valid_reg <= a_valid_reg;
        end
    end

    assign quot_ext = signed'(CLAMP_W'(b_quot_reg));
    assign level    = b_neg_reg ? (OUT_OFFSET - quot_ext) : (quot_ext + OUT_OFFSET);
    assign hi_level = CLAMP_W'(cfg.max_value) + OUT_OFFSET;
    assign lo_level = CLAMP_W'(cfg.min_value) + OUT_OFFSET;

    // apply the upper bound first, the lower bound wins
    always_comb
    begin
        clamped = level;
        if (level > hi_level)
        begin
            clamped = hi_level;
        end
        if (clamped < lo_level)
        begin
            clamped = lo_level;
        end
    end

    assign out_wr   = b_valid_reg;
    assign out_rd   = pop && !empty;
    assign empty    = (out_count_reg == '0);
    assign out_byte = out_mem_reg[out_rd_ptr_reg];

    always_ff @(posedge clk)
    begin
        if (out_wr)
        begin
            out_mem_reg[out_wr_ptr_reg] <= clamped[7:0];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_wr_ptr_reg <= '0;
            out_rd_ptr_reg <= '0;
            out_count_reg  <= '0;
        end
        else
        begin
            if (out_wr)
            begin
                out_wr_ptr_reg <= out_wr_ptr_reg + 1'b1;
            end
            if (out_rd)
            begin
                out_rd_ptr_reg <= out_rd_ptr_reg + 1'b1;
            end
            if (out_wr && !out_rd)
            begin
                out_count_reg <= out_count_reg + 1'b1;
            end
            else if (out_rd && !out_wr)
            begin
                out_count_reg <= out_count_reg - 1'b1;
            end
        end
    end

endmodule

>>> rtl/depthwise_mac_requantize.sv
// Path: a last tap's window goes through the job queue, the back end's product and
// quotient registers and the result queue; it waits while the result queue is backed up.
// Throughput: one tap per cycle while not full; the accumulator adds once per cycle
// and the 32x32 requantize multiplier takes one closed window per cycle unless stalled.
// Reset (rst_n low, asynchronous): accumulator zero, queues empty,
// min_value -128, max_value 127.
module depthwise_mac_requantize (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               push,
    output logic                               full,
    input  logic signed [15:0]                 sample,
    input  logic signed [15:0]                 weight,
    input  logic signed [31:0]                 bias,
    input  logic        [31:0]                 scale,
    input  logic                               first_tap,
    input  logic                               last_tap,
    output logic                               empty,
    input  logic                               pop,
    output logic        [7:0]                  out_byte,
    input  logic                               cfg_write,
    input  logic [dmr_pkg::CFG_ADDR_W-1:0]     cfg_addr,
    input  logic [dmr_pkg::CFG_DATA_W-1:0]     cfg_data
);
    import dmr_pkg::*;

    clamp_cfg_t cfg_reg;
    logic       accept;
    logic       job_push;
    job_t       job_in;
    logic       job_valid;
    logic       job_pop;
    job_t       job_out;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.min_value <= -8'sd128;
            cfg_reg.max_value <= 8'sd127;
        end
        else if (cfg_write)
        begin
            unique case (cfg_reg_t'(cfg_addr))
                REG_MIN_VALUE: cfg_reg.min_value <= signed'(cfg_data);
                REG_MAX_VALUE: cfg_reg.max_value <= signed'(cfg_data);
                default: ;
            endcase
        end
    end

    assign accept = push && !full;

    dmr_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .accept    (accept),
        .sample    (sample),
        .weight    (weight),
        .bias      (bias),
        .scale     (scale),
        .first_tap (first_tap),
        .last_tap  (last_tap),
        .job_push  (job_push),
        .job       (job_in)
    );

    dmr_job_queue u_job_queue (
        .clk   (clk),
        .rst_n (rst_n),
        .push  (job_push),
        .wdata (job_in),
        .full  (full),
        .pop   (job_pop),
        .valid (job_valid),
        .rdata (job_out)
    );

    dmr_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .job_valid (job_valid),
        .job       (job_out),
        .job_pop   (job_pop),
        .cfg       (cfg_reg),
        .empty     (empty),
        .pop       (pop),
        .out_byte  (out_byte)
    );

endmodule

>>> rtl/dmr_checker.sv
`include "depthwise_mac_requantize_macros.svh"

module dmr_checker (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               push,
    input  logic                               full,
    input  logic                               last_tap,
    input  logic                               empty,
    input  logic                               pop,
    input  logic        [7:0]                  out_byte,
    input  logic                               cfg_write,
    input  logic [dmr_pkg::CFG_ADDR_W-1:0]     cfg_addr,
    input  logic [dmr_pkg::CFG_DATA_W-1:0]     cfg_data
);
    import dmr_pkg::*;

    logic [3:0] pending_reg;
    logic [7:0] min_reg;
    logic [7:0] max_reg;
    logic [7:0] lo_byte;
    logic [7:0] hi_byte;
    logic       put;
    logic       take;
    logic       window_ok;
    logic       byte_ok;

    assign put       = push && !full && last_tap;
    assign take      = pop && !empty;
    assign lo_byte   = {~min_reg[7], min_reg[6:0]};
    assign hi_byte   = {~max_reg[7], max_reg[6:0]};
    assign window_ok = !empty && (lo_byte <= hi_byte);
    assign byte_ok   = (out_byte >= lo_byte) && (out_byte <= hi_byte);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pending_reg <= '0;
            min_reg     <= 8'h80;
            max_reg     <= 8'h7f;
        end
        else
        begin
            if (put && !take)
            begin
                pending_reg <= pending_reg + 1'b1;
            end
            else if (take && !put)
            begin
                pending_reg <= pending_reg - 1'b1;
            end
            if (cfg_write && (cfg_reg_t'(cfg_addr) == REG_MIN_VALUE))
            begin
                min_reg <= cfg_data;
            end
            if (cfg_write && (cfg_reg_t'(cfg_addr) == REG_MAX_VALUE))
            begin
                max_reg <= cfg_data;
            end
        end
    end

    `DMR_ASSERT_IMP(a_no_result_without_window, pending_reg == 4'd0, empty)
    `DMR_ASSERT_IMP(a_full_needs_pending, full, pending_reg != 4'd0)
    `DMR_ASSERT_IMP(a_out_in_range, window_ok, byte_ok)
    `DMR_ASSERT_NEXT(a_result_holds, !empty && !pop, !empty && $stable(out_byte))

endmodule

bind depthwise_mac_requantize dmr_checker u_dmr_checker (.*);

>>> test/testbench.sv
module testbench;

    import dmr_pkg::*;

    localparam logic [CFG_ADDR_W-1:0] REG_SPARE_2 = 2'd2;
    localparam logic [CFG_ADDR_W-1:0] REG_SPARE_3 = 2'd3;
    localparam logic [31:0] SCALE_ONE = 32'h0100_0000;
    localparam logic [31:0] SCALE_HALF = 32'h0080_0000;
    localparam int DRAIN_CYCLES = 8;
    localparam int PHASES = 8;
    localparam int PHASE_ITEMS = 150;
    localparam int ROWS = 19;

    typedef struct {
        logic signed [15:0] sample;
        logic signed [15:0] weight;
        logic signed [31:0] bias;
        logic        [31:0] scale;
        logic               first_tap;
        logic               last_tap;
    } tap_t;

    typedef struct {
        logic signed [15:0] sample;
        logic signed [15:0] weight;
        logic signed [31:0] bias;
        logic        [31:0] scale;
        logic               first_tap;
        logic               last_tap;
        bit                 typed;
        logic        [7:0]  want;
    } tap_row_t;

    logic clk = 1'b0;
    logic rst_n;
    logic push;
    logic full;
    logic signed [15:0] sample;
    logic signed [15:0] weight;
    logic signed [31:0] bias;
    logic [31:0] scale;
    logic first_tap;
    logic last_tap;
    logic empty;
    logic pop;
    logic [7:0] out_byte;
    logic cfg_write;
    logic [CFG_ADDR_W-1:0] cfg_addr;
    logic [CFG_DATA_W-1:0] cfg_data;

    logic signed [31:0] acc_model = 32'sd0;
    logic signed [7:0] clamp_min = -8'sd128;
    logic signed [7:0] clamp_max = 8'sd127;
    logic [7:0] pending_bytes [$];
    logic [7:0] want_byte;
    int fail_count = 0;
    bit steady = 1'b0;

    tap_row_t directed_rows [ROWS];
    int phase_min [PHASES] = '{-128, 0, -128, 127, 10, -50, 0, 0};
    int phase_max [PHASES] = '{127, 0, -128, 127, -10, 50, 0, 0};

    depthwise_mac_requantize dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .full      (full),
        .sample    (sample),
        .weight    (weight),
        .bias      (bias),
        .scale     (scale),
        .first_tap (first_tap),
        .last_tap  (last_tap),
        .empty     (empty),
        .pop       (pop),
        .out_byte  (out_byte),
        .cfg_write (cfg_write),
        .cfg_addr  (cfg_addr),
        .cfg_data  (cfg_data)
    );

    always
    begin
        #10 clk = 1'b1;
        #10 clk = 1'b0;
    end

    function automatic logic [7:0] requantize(input logic signed [31:0] sum,
                                              input logic [31:0] scl);
        longint unsigned mag;
        longint unsigned q;
        longint v;
        longint hi;
        longint lo;
        mag = (sum < 0) ? longint'(-longint'(sum)) : longint'(sum);
        q = (mag * {32'd0, scl} + 64'h0080_0000) >> 24;
        v = (sum < 0) ? -longint'(q) : longint'(q);
        v = v + 128;
        if (v > 32767)
            v = 32767;
        if (v < -32768)
            v = -32768;
        hi = longint'(clamp_max) + 128;
        lo = longint'(clamp_min) + 128;
        if (v > hi)
            v = hi;
        if (v < lo)
            v = lo;
        if (v < 0)
            v = 0;
        if (v > 255)
            v = 255;
        return v[7:0];
    endfunction

    task automatic accumulate_tap(input tap_t t, output bit emits, output logic [7:0] val);
        logic signed [31:0] prod;
        prod = 32'(longint'(t.sample) * longint'(t.weight));
        if (t.first_tap)
            acc_model = t.bias;
        acc_model = acc_model + prod;
        emits = t.last_tap;
        val = t.last_tap ? requantize(acc_model, t.scale) : 8'd0;
    endtask

    task automatic send_tap(input tap_t t, input bit typed, input logic [7:0] want);
        bit emits;
        logic [7:0] val;
        @(negedge clk);
        while (!steady && $urandom_range(0, 99) < 20)
        begin
            push <= 1'b0;
            @(negedge clk);
        end
        push <= 1'b1;
        sample <= t.sample;
        weight <= t.weight;
        bias <= t.bias;
        scale <= t.scale;
        first_tap <= t.first_tap;
        last_tap <= t.last_tap;
        forever
        begin
            @(posedge clk);
            if (!full)
                break;
        end
        accumulate_tap(t, emits, val);
        if (emits)
            pending_bytes.push_back(typed ? want : val);
    endtask

    task automatic stop_sending();
        @(negedge clk);
        push <= 1'b0;
    endtask

    task automatic wait_drained();
        while (pending_bytes.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    task automatic write_reg(input logic [CFG_ADDR_W-1:0] idx,
                             input logic [CFG_DATA_W-1:0] val);
        @(negedge clk);
        cfg_write <= 1'b1;
        cfg_addr <= idx;
        cfg_data <= val;
        @(posedge clk);
        if (idx == REG_MIN_VALUE)
            clamp_min = val;
        else if (idx == REG_MAX_VALUE)
            clamp_max = val;
    endtask

    function automatic logic [15:0] rand_half();
        case ($urandom_range(0, 3))
            1: return 16'($urandom_range(0, 64)) - 16'd32;
            2:
                case ($urandom_range(0, 3))
                    0: return 16'h8000;
                    1: return 16'h7FFF;
                    2: return 16'h0000;
                    default: return 16'hFFFF;
                endcase
            default: return 16'($urandom);
        endcase
    endfunction

    function automatic logic [31:0] rand_bias();
        logic [31:0] mag;
        if ($urandom_range(0, 3) == 0)
            return $urandom;
        mag = $urandom >> $urandom_range(0, 31);
        return $urandom_range(0, 1) ? -mag : mag;
    endfunction

    function automatic logic [31:0] rand_scale();
        case ($urandom_range(0, 3))
            0: return $urandom;
            1: return $urandom_range(0, 32'h0200_0000);
            default: return $urandom >> $urandom_range(0, 31);
        endcase
    endfunction

    function automatic tap_t rand_tap(input logic first, input logic last);
        tap_t t;
        t.sample = rand_half();
        t.weight = rand_half();
        t.bias = rand_bias();
        t.scale = rand_scale();
        t.first_tap = first;
        t.last_tap = last;
        return t;
    endfunction

    always @(negedge clk)
        pop <= rst_n && (steady || $urandom_range(0, 99) >= 20);

    always @(posedge clk)
    begin
        if (rst_n && pop && !empty)
        begin
            if (pending_bytes.size() == 0)
            begin
                $error("out_byte expected none actual %0d", out_byte);
                fail_count++;
            end
            else
            begin
                want_byte = pending_bytes.pop_front();
                if (out_byte !== want_byte)
                begin
                    $error("out_byte expected %0d actual %0d", want_byte, out_byte);
                    fail_count++;
                end
            end
        end
    end

    initial
    begin
        #4_000_000;
        $display("FAIL");
        $finish;
    end

    initial
    begin
        tap_t t;
        int sent;
        int len;
        rst_n = 1'b0;
        push = 1'b0;
        pop = 1'b0;
        sample = '0;
        weight = '0;
        bias = '0;
        scale = '0;
        first_tap = 1'b0;
        last_tap = 1'b0;
        cfg_write = 1'b0;
        cfg_addr = '0;
        cfg_data = '0;

        directed_rows = '{
            '{16'sd0, 16'sd0, 32'sd0, 32'd0, 1'b0, 1'b1, 1'b1, 8'd128},
            '{16'sd1, 16'sd1, 32'sd0, SCALE_ONE, 1'b1, 1'b1, 1'b1, 8'd129},
            '{16'sh8000, 16'sh8000, 32'sd0, SCALE_ONE, 1'b1, 1'b1, 1'b1, 8'd255},
            '{16'sh7FFF, 16'sh8000, 32'sd0, SCALE_ONE, 1'b1, 1'b1, 1'b1, 8'd0},
            '{16'sd0, 16'sd0, 32'sd1, SCALE_HALF, 1'b1, 1'b1, 1'b1, 8'd129},
            '{16'sd0, 16'sd0, -32'sd1, SCALE_HALF, 1'b1, 1'b1, 1'b1, 8'd127},
            '{16'sd0, 16'sd0, 32'sd3, SCALE_HALF, 1'b1, 1'b1, 1'b1, 8'd130},
            '{16'sd0, 16'sd0, 32'sd1, 32'h007F_FFFF, 1'b1, 1'b1, 1'b1, 8'd128},
            '{16'sd3, 16'sd4, 32'sd100, 32'hFFFF_FFFF, 1'b1, 1'b0, 1'b0, 8'd0},
            '{-16'sd5, 16'sd7, 32'sh5A5A_5A5A, 32'hFFFF_FFFF, 1'b0, 1'b0, 1'b0, 8'd0},
            '{16'sd2, 16'sd2, 32'shA5A5_A5A5, SCALE_ONE, 1'b0, 1'b1, 1'b1, 8'd209},
            '{16'sd1, 16'sd1, 32'sd0, SCALE_ONE, 1'b0, 1'b1, 1'b1, 8'd210},
            '{16'sd1, 16'sd1, 32'sh7FFF_FFFF, 32'd0, 1'b1, 1'b0, 1'b0, 8'd0},
            '{16'sd0, 16'sd5, 32'sd0, 32'hFFFF_FFFF, 1'b0, 1'b1, 1'b1, 8'd0},
            '{16'sh7FFF, 16'sh7FFF, 32'sh7FFF_FFFF, 32'd0, 1'b1, 1'b1, 1'b1, 8'd128},
            '{16'sd0, 16'sd0, 32'sh7FFF_FFFF, 32'hFFFF_FFFF, 1'b1, 1'b1, 1'b1, 8'd255},
            '{16'sd0, 16'sd0, 32'sh8000_0000, SCALE_ONE, 1'b1, 1'b1, 1'b1, 8'd0},
            '{16'shFFFF, 16'shFFFF, 32'sh1234_5678, 32'h0000_0100, 1'b1, 1'b0, 1'b0, 8'd0},
            '{16'sh7FFF, -16'sd3, 32'sd0, 32'h0000_3456, 1'b0, 1'b1, 1'b0, 8'd0}
        };

        repeat (4) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        foreach (directed_rows[i])
        begin
            t.sample = directed_rows[i].sample;
            t.weight = directed_rows[i].weight;
            t.bias = directed_rows[i].bias;
            t.scale = directed_rows[i].scale;
            t.first_tap = directed_rows[i].first_tap;
            t.last_tap = directed_rows[i].last_tap;
            send_tap(t, directed_rows[i].typed, directed_rows[i].want);
        end
        stop_sending();

        for (int p = 0; p < PHASES; p++)
        begin
            wait_drained();
            if (p >= PHASES - 2)
            begin
                phase_min[p] = $urandom_range(0, 255) - 128;
                phase_max[p] = $urandom_range(0, 255) - 128;
            end
            write_reg($urandom_range(0, 1) ? REG_SPARE_2 : REG_SPARE_3, 8'($urandom));
            write_reg(REG_MIN_VALUE, 8'(phase_min[p]));
            write_reg(REG_MAX_VALUE, 8'(phase_max[p]));
            @(negedge clk);
            cfg_write <= 1'b0;
            steady = (p == 2);

            sent = 0;
            while (sent < PHASE_ITEMS)
            begin
                if ($urandom_range(0, 99) < 85)
                begin
                    len = $urandom_range(1, 9);
                    for (int k = 0; k < len; k++)
                        send_tap(rand_tap(k == 0, k == len - 1), 1'b0, 8'd0);
                    sent += len;
                end
                else
                begin
                    send_tap(rand_tap(1'($urandom_range(0, 1)), 1'($urandom_range(0, 1))),
                             1'b0, 8'd0);
                    sent++;
                end
            end
            stop_sending();
        end

        steady = 1'b0;
        wait_drained();
        if (fail_count == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end

endmodule

>>> filelist.f
+incdir+rtl
rtl/dmr_pkg.sv
rtl/dmr_front.sv
rtl/dmr_job_queue.sv
rtl/dmr_back.sv
rtl/depthwise_mac_requantize.sv
rtl/dmr_checker.sv
test/testbench.sv
